// ===== sv/sas_pkg.sv =====
// ----------------------------------------------------------------------------
// sas_pkg
// Types, codes and constants shared by the select / anticollision sequencer.
// ----------------------------------------------------------------------------
package sas_pkg;

	localparam logic [7:0] NVB_SELECT     = 8'h70;
	localparam logic [7:0] SAK_CASCADE    = 8'h04;
	localparam logic [7:0] MAX_KNOWN_BITS = 8'd80;
	localparam logic [5:0] LEVEL_BITS     = 6'd32;
	localparam logic [7:0] TAG_CT         = 8'h88;
	localparam logic [7:0] SEL_CL1        = 8'h93;
	localparam logic [7:0] SEL_CL2        = 8'h95;
	localparam logic [7:0] SEL_CL3        = 8'h97;

	localparam logic [1:0] LEVEL_1 = 2'd1;
	localparam logic [1:0] LEVEL_2 = 2'd2;
	localparam logic [1:0] LEVEL_3 = 2'd3;

	localparam logic [1:0] CFG_KNOWN_BIT_COUNT  = 2'd0;
	localparam logic [1:0] CFG_KNOWN_UID_LENGTH = 2'd1;
	localparam logic [1:0] CFG_KNOWN_UID_LOW    = 2'd2;
	localparam logic [1:0] CFG_KNOWN_UID_HIGH   = 2'd3;

	typedef enum logic {
		OP_START  = 1'b0,
		OP_RESULT = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		LINK_OK      = 2'd0,
		LINK_COLL    = 2'd1,
		LINK_TIMEOUT = 2'd2,
		LINK_ERROR   = 2'd3
	} link_t;

	typedef enum logic [1:0] {
		KIND_FRAME = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		OUT_OK       = 3'd0,
		OUT_BAD_ARG  = 3'd1,
		OUT_INTERNAL = 3'd2,
		OUT_BAD_SAK  = 3'd3,
		OUT_TIMEOUT  = 3'd4,
		OUT_LINK     = 3'd5
	} outcome_t;

	typedef logic [8:0][7:0] frame_t;
	typedef logic [9:0][7:0] uid_t;

	typedef struct packed {
		logic [7:0]  known_bits;
		logic [3:0]  known_len;
		logic [63:0] uid_low;
		logic [15:0] uid_high;
	} cfg_t;

	typedef struct packed {
		op_t             op;
		link_t           link;
		logic [5:0]      cbit;
		logic [6:0][7:0] reply;
		logic [2:0]      rcount;
		logic [2:0]      rlast;
	} item_t;

	typedef struct packed {
		logic [1:0] level;
		logic [5:0] lkb;
		logic       busy;
		frame_t     fs;
		uid_t       us;
	} state_t;

	typedef struct packed {
		kind_t           kind;
		logic [6:0][7:0] frame;
		logic [2:0]      count;
		logic [2:0]      last;
		logic            crc;
		outcome_t        outcome;
		uid_t            uid;
		logic [3:0]      uid_len;
		logic [7:0]      sak;
	} result_t;

endpackage

// ===== sv/iso14443a_select_anticollision_core.sv =====
// ----------------------------------------------------------------------------
// iso14443a_select_anticollision_core
// Reader-side ISO 14443A select / anticollision sequencer. Accepts one beat
// on the input channel every clock while in_stall is low; a start beat or
// an outcome beat while a selection runs yields one result beat through the
// input register, one step stage and the result register, an outcome beat
// while idle yields none. The step stage reads and rewrites the cascade
// level, bit count and byte stores. The result register lets the next beat
// enter while a result waits. Known UID registers are read live at start
// and at each new cascade level and should only be written between beats.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module iso14443a_select_anticollision_core import sas_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [1:0]  link_status,
	input  logic [5:0]  collision_bit,
	input  logic [55:0] reply_bytes,
	input  logic [2:0]  reply_count,
	input  logic [2:0]  reply_last_bits,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [55:0] frame_bytes,
	output logic [2:0]  frame_count,
	output logic [2:0]  frame_last_bits,
	output logic        append_crc,
	output logic [2:0]  outcome,
	output logic [63:0] uid_low,
	output logic [15:0] uid_high,
	output logic [3:0]  uid_length,
	output logic [7:0]  select_ack
);

	cfg_t       cfg_q;
	item_t      item_in;
	item_t      item_s1;
	logic       valid_s1;
	result_t    res_s2;
	logic       valid_s2;

	logic [1:0] level_q;
	logic [5:0] lkb_q;
	logic       busy_q;
	frame_t     fs_q;
	uid_t       us_q;

	state_t     st;
	state_t     nx;
	result_t    res;
	logic       has_result;
	logic       can_move;
	logic       advance;
	logic       accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_KNOWN_BIT_COUNT:  cfg_q.known_bits <= cfg_data[7:0];
				CFG_KNOWN_UID_LENGTH: cfg_q.known_len  <= cfg_data[3:0];
				CFG_KNOWN_UID_LOW:    cfg_q.uid_low    <= cfg_data;
				CFG_KNOWN_UID_HIGH:   cfg_q.uid_high   <= cfg_data[15:0];
				default:              cfg_q            <= cfg_q;
			endcase
		end
	end

	assign item_in = '{
		op:     op_t'(opcode),
		link:   link_t'(link_status),
		cbit:   collision_bit,
		reply:  reply_bytes,
		rcount: reply_count,
		rlast:  reply_last_bits
	};

	assign can_move = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && can_move;
	assign in_stall = valid_s1 && !can_move;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;
			if (advance) valid_s2 <= has_result;
			else if (!out_stall) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) item_s1 <= item_in;
		if (advance && has_result) res_s2 <= res;
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LEVEL_1;
			lkb_q   <= 6'd0;
			busy_q  <= 1'b0;
		end else if (advance) begin
			level_q <= nx.level;
			lkb_q   <= nx.lkb;
			busy_q  <= nx.busy;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fs_q <= nx.fs;
			us_q <= nx.us;
		end
	end

	assign st = '{level: level_q, lkb: lkb_q, busy: busy_q, fs: fs_q, us: us_q};

	sas_step u_step (
		.item       (item_s1),
		.st         (st),
		.cfg        (cfg_q),
		.nx         (nx),
		.res        (res),
		.has_result (has_result)
	);

	assign out_valid       = valid_s2;
	assign kind            = res_s2.kind;
	assign frame_bytes     = res_s2.frame;
	assign frame_count     = res_s2.count;
	assign frame_last_bits = res_s2.last;
	assign append_crc      = res_s2.crc;
	assign outcome         = res_s2.outcome;
	assign uid_low         = res_s2.uid[7:0];
	assign uid_high        = res_s2.uid[9:8];
	assign uid_length      = res_s2.uid_len;
	assign select_ack      = res_s2.sak;

endmodule

// ===== sv/sas_level.sv =====
// ----------------------------------------------------------------------------
// sas_level
// Cascade level setup: SEL code, optional cascade tag and known UID bytes.
// ----------------------------------------------------------------------------
module sas_level import sas_pkg::*; (
	input  logic [1:0] level,
	input  cfg_t       cfg,
	input  uid_t       uid,
	input  frame_t     fs_in,
	output frame_t     fs_out,
	output logic [5:0] lkb
);

	logic [7:0]      sel;
	logic            ct;
	logic [7:0]      known;
	logic [8:0]      known_ct;
	logic [5:0]      nb;
	logic [2:0]      maxb;
	logic [2:0]      nbc;
	logic [3:0][7:0] ub;

	always_comb begin
		case (level)
			LEVEL_2: begin
				sel   = SEL_CL2;
				ct    = (cfg.known_bits != 8'd0) && (cfg.known_len > 4'd7);
				known = (cfg.known_bits > 8'd24) ? cfg.known_bits - 8'd24 : 8'd0;
				for (int c = 0; c < 4; c++) ub[c] = uid[3 + c];
			end
			LEVEL_3: begin
				sel   = SEL_CL3;
				ct    = 1'b0;
				known = (cfg.known_bits > 8'd48) ? cfg.known_bits - 8'd48 : 8'd0;
				for (int c = 0; c < 4; c++) ub[c] = uid[6 + c];
			end
			default: begin
				sel   = SEL_CL1;
				ct    = (cfg.known_bits != 8'd0) && (cfg.known_len > 4'd4);
				known = cfg.known_bits;
				for (int c = 0; c < 4; c++) ub[c] = uid[c];
			end
		endcase

		known_ct = {1'b0, known} + (ct ? 9'd8 : 9'd0);
		lkb      = (known_ct >= 9'd32) ? LEVEL_BITS : known_ct[5:0];

		nb   = {1'b0, known[7:3]} + {5'd0, |known[2:0]};
		maxb = ct ? 3'd3 : 3'd4;
		nbc  = (nb > {3'd0, maxb}) ? maxb : nb[2:0];

		fs_out    = fs_in;
		fs_out[0] = sel;
		if (ct) begin
			fs_out[2] = TAG_CT;
			for (int k = 3; k <= 5; k++) begin
				if (3'(k - 3) < nbc) fs_out[k] = ub[k - 3];
			end
		end else begin
			for (int k = 2; k <= 5; k++) begin
				if (3'(k - 2) < nbc) fs_out[k] = ub[k - 2];
			end
		end
	end

endmodule

// ===== sv/sas_emit.sv =====
// ----------------------------------------------------------------------------
// sas_emit
// Builds the anticollision or SELECT frame from the frame store.
// ----------------------------------------------------------------------------
module sas_emit import sas_pkg::*; (
	input  frame_t          fs_in,
	input  logic [5:0]      lkb,
	output frame_t          fs_out,
	output logic [6:0][7:0] frame,
	output logic [2:0]      count,
	output logic [2:0]      last,
	output logic            crc
);

	logic [2:0] whole;

	always_comb begin
		fs_out = fs_in;
		whole  = 3'd2 + {1'b0, lkb[4:3]};
		if (lkb >= LEVEL_BITS) begin
			fs_out[1] = NVB_SELECT;
			fs_out[6] = fs_in[2] ^ fs_in[3] ^ fs_in[4] ^ fs_in[5];
			count     = 3'd7;
			last      = 3'd0;
			crc       = 1'b1;
		end else begin
			last      = lkb[2:0];
			fs_out[1] = {1'b0, whole, 1'b0, last};
			count     = whole + {2'b00, last != 3'd0};
			crc       = 1'b0;
		end
		for (int i = 0; i < 7; i++) begin
			frame[i] = (3'(i) < count) ? fs_out[i] : 8'd0;
		end
	end

endmodule

// ===== sv/sas_step.sv =====
// ----------------------------------------------------------------------------
// sas_step
// One sequencer step: reply merge, collision handling, UID capture, SAK
// decision and next-state / result selection.
// ----------------------------------------------------------------------------
module sas_step import sas_pkg::*; (
	input  item_t   item,
	input  state_t  st,
	input  cfg_t    cfg,
	output state_t  nx,
	output result_t res,
	output logic    has_result
);

	uid_t            us_cfg;
	uid_t            us_c;
	frame_t          fs_m;
	frame_t          fs_c;
	logic            full;
	logic [3:0]      at;
	logic [2:0]      align;
	logic [3:0]      room;
	logic [2:0]      n;
	logic [7:0]      mask;
	logic [5:0]      cm1;
	logic [3:0]      idx;
	logic [5:0]      lkb_c;
	logic            ct_s;
	logic [7:0]      sak;
	logic            is_start;
	logic            use_level;

	logic [1:0]      lvl_level;
	uid_t            lvl_uid;
	frame_t          lvl_fs_in;
	frame_t          lvl_fs;
	logic [5:0]      lvl_lkb;

	frame_t          em_fs_in;
	logic [5:0]      em_lkb;
	frame_t          em_fs;
	logic [6:0][7:0] em_frame;
	logic [2:0]      em_count;
	logic [2:0]      em_last;
	logic            em_crc;

	assign us_cfg   = {cfg.uid_high, cfg.uid_low};
	assign is_start = (item.op == OP_START);

	// reply merge at the current bit position
	always_comb begin
		logic [3:0] off;
		logic [7:0] b;
		full  = (st.lkb >= LEVEL_BITS);
		at    = full ? 4'd6 : 4'd2 + {2'b00, st.lkb[4:3]};
		align = full ? 3'd0 : st.lkb[2:0];
		room  = 4'd9 - at;
		n     = ({1'b0, item.rcount} < room) ? item.rcount : room[2:0];
		mask  = (8'd1 << align) - 8'd1;
		fs_m  = st.fs;
		for (int k = 2; k <= 8; k++) begin
			off = 4'(k) - at;
			b   = item.reply[off[2:0]];
			if ((4'(k) >= at) && (off < {1'b0, n})) begin
				if ((off == 4'd0) && (align != 3'd0)) b = (st.fs[k] & mask) | (b & ~mask);
				fs_m[k] = b;
			end
		end
	end

	// collision: set the chosen bit
	always_comb begin
		cm1   = item.cbit - 6'd1;
		idx   = 4'd2 + {1'b0, cm1[5:3]};
		lkb_c = (item.cbit > LEVEL_BITS) ? LEVEL_BITS : item.cbit;
		fs_c  = fs_m;
		for (int k = 2; k <= 8; k++) begin
			if (idx == 4'(k)) fs_c[k] = fs_m[k] | (8'd1 << cm1[2:0]);
		end
	end

	// UID capture after SELECT
	always_comb begin
		ct_s = (fs_m[2] == TAG_CT);
		sak  = fs_m[6];
		us_c = st.us;
		for (int i = 0; i < 4; i++) begin
			case (st.level)
				LEVEL_2: begin
					if (ct_s) begin
						if (i < 3) us_c[3 + i] = fs_m[3 + i];
					end else begin
						us_c[3 + i] = fs_m[2 + i];
					end
				end
				LEVEL_3: begin
					if (ct_s) begin
						if (i < 3) us_c[6 + i] = fs_m[3 + i];
					end else begin
						us_c[6 + i] = fs_m[2 + i];
					end
				end
				default: begin
					if (ct_s) begin
						if (i < 3) us_c[i] = fs_m[3 + i];
					end else begin
						us_c[i] = fs_m[2 + i];
					end
				end
			endcase
		end
	end

	assign lvl_level = is_start ? LEVEL_1 : st.level + 2'd1;
	assign lvl_uid   = is_start ? us_cfg : us_c;
	assign lvl_fs_in = is_start ? st.fs : fs_m;

	sas_level u_level (
		.level  (lvl_level),
		.cfg    (cfg),
		.uid    (lvl_uid),
		.fs_in  (lvl_fs_in),
		.fs_out (lvl_fs),
		.lkb    (lvl_lkb)
	);

	assign use_level = is_start || ((item.link == LINK_OK) && full);
	assign em_fs_in  = use_level ? lvl_fs :
	                   (item.link == LINK_COLL) ? fs_c : fs_m;
	assign em_lkb    = use_level ? lvl_lkb :
	                   (item.link == LINK_COLL) ? lkb_c : LEVEL_BITS;

	sas_emit u_emit (
		.fs_in  (em_fs_in),
		.lkb    (em_lkb),
		.fs_out (em_fs),
		.frame  (em_frame),
		.count  (em_count),
		.last   (em_last),
		.crc    (em_crc)
	);

	always_comb begin
		logic       emit;
		logic       fail;
		outcome_t   code;
		nx         = st;
		res        = '0;
		has_result = 1'b0;
		emit       = 1'b0;
		fail       = 1'b0;
		code       = OUT_OK;

		if (is_start) begin
			has_result = 1'b1;
			if (cfg.known_bits > MAX_KNOWN_BITS) begin
				fail = 1'b1;
				code = OUT_BAD_ARG;
			end else begin
				nx.us    = us_cfg;
				nx.level = LEVEL_1;
				nx.busy  = 1'b1;
				nx.lkb   = lvl_lkb;
				emit     = 1'b1;
			end
		end else if (st.busy) begin
			has_result = 1'b1;
			case (item.link)
				LINK_OK: begin
					nx.fs = fs_m;
					if (!full) begin
						nx.lkb = LEVEL_BITS;
						emit   = 1'b1;
					end else begin
						nx.us = us_c;
						if ((item.rcount != 3'd3) || (item.rlast != 3'd0)) begin
							fail = 1'b1;
							code = OUT_BAD_SAK;
						end else if ((sak & SAK_CASCADE) != 8'd0) begin
							if (st.level >= LEVEL_3) begin
								fail = 1'b1;
								code = OUT_INTERNAL;
							end else begin
								nx.level = st.level + 2'd1;
								nx.lkb   = lvl_lkb;
								emit     = 1'b1;
							end
						end else begin
							nx.busy     = 1'b0;
							res.kind    = KIND_DONE;
							res.uid     = us_c;
							res.uid_len = 4'({2'b00, st.level} * 4'd3 + 4'd1);
							res.sak     = sak;
						end
					end
				end
				LINK_COLL: begin
					nx.fs = fs_m;
					if (item.cbit <= st.lkb) begin
						fail = 1'b1;
						code = OUT_INTERNAL;
					end else begin
						nx.lkb = lkb_c;
						emit   = 1'b1;
					end
				end
				LINK_TIMEOUT: begin
					fail = 1'b1;
					code = OUT_TIMEOUT;
				end
				default: begin
					fail = 1'b1;
					code = OUT_LINK;
				end
			endcase
		end

		if (emit) begin
			nx.fs     = em_fs;
			res.kind  = KIND_FRAME;
			res.frame = em_frame;
			res.count = em_count;
			res.last  = em_last;
			res.crc   = em_crc;
		end
		if (fail) begin
			nx.busy     = 1'b0;
			res.kind    = KIND_ERROR;
			res.outcome = code;
		end
	end

endmodule

// ===== sv/sas_checker.sv =====
// ----------------------------------------------------------------------------
// sas_checker
// Port-level checks for the select / anticollision sequencer, bound to the
// top level.
// ----------------------------------------------------------------------------
module sas_checker import sas_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  kind,
	input logic [2:0]  frame_count,
	input logic [2:0]  frame_last_bits,
	input logic        append_crc,
	input logic [3:0]  uid_length
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(frame_count))
		else $error("result beat changed while stalled");

	// input only backs up behind a stalled, full result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// a SELECT frame is always seven whole bytes
	a_select_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_FRAME && append_crc |->
			frame_count == 3'd7 && frame_last_bits == 3'd0)
		else $error("malformed SELECT frame");

	// non-frame results carry no frame
	a_no_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_FRAME |-> frame_count == 3'd0 && !append_crc)
		else $error("frame fields set on a finish beat");

	// a finished selection reports a legal UID size
	a_uid_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_DONE |->
			uid_length == 4'd4 || uid_length == 4'd7 || uid_length == 4'd10)
		else $error("illegal UID size");

endmodule

bind iso14443a_select_anticollision_core sas_checker u_sas_checker (.*);

// ===== sim/iso14443a_select_anticollision_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iso14443a_select_anticollision_core_tb
// Self-checking bench for the select / anticollision sequencer. A scoreboard
// keeps its own copy of the cascade level, bit count and byte stores, predicts
// one result beat per accepted start or running outcome, and checks each
// result beat in order. Directed beats cover the corner cases, then random
// phases run mostly well-formed card dialogs with noise, under several known
// UID settings and random idling on both channels.
// ----------------------------------------------------------------------------
module iso14443a_select_anticollision_core_tb;
	import sas_pkg::*;

	localparam int unsigned QUIET_LIMIT = 5000;
	localparam int unsigned SETTLE      = 6;

	class sel_scoreboard;
		logic [7:0]  kbits;
		logic [3:0]  klen;
		logic [63:0] klow;
		logic [15:0] khigh;
		int unsigned level;
		int unsigned lkb;
		bit          busy;
		logic [7:0]  fs [9];
		logic [7:0]  us [10];
		result_t     awaited [$];
		int unsigned faults;

		function new();
			kbits  = '0;
			klen   = '0;
			klow   = '0;
			khigh  = '0;
			level  = 1;
			lkb    = 0;
			busy   = 1'b0;
			faults = 0;
			foreach (fs[i]) fs[i] = '0;
			foreach (us[i]) us[i] = '0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [63:0] data);
			case (idx)
				CFG_KNOWN_BIT_COUNT:  kbits = data[7:0];
				CFG_KNOWN_UID_LENGTH: klen  = data[3:0];
				CFG_KNOWN_UID_LOW:    klow  = data;
				default:              khigh = data[15:0];
			endcase
		endfunction

		function result_t stop_with(outcome_t code);
			result_t r;
			busy      = 1'b0;
			r         = '0;
			r.kind    = KIND_ERROR;
			r.outcome = code;
			return r;
		endfunction

		function result_t frame_beat();
			result_t r;
			int unsigned used, whole, lastb, i;
			r = '0;
			if (lkb >= LEVEL_BITS) begin
				fs[1] = NVB_SELECT;
				fs[6] = fs[2] ^ fs[3] ^ fs[4] ^ fs[5];
				used  = 7;
				lastb = 0;
				r.crc = 1'b1;
			end else begin
				whole = 2 + lkb / 8;
				lastb = lkb % 8;
				fs[1] = 8'((whole << 4) + lastb);
				used  = whole + ((lastb != 0) ? 1 : 0);
			end
			for (i = 0; i < used; i++) r.frame[i] = fs[i];
			r.kind  = KIND_FRAME;
			r.count = 3'(used);
			r.last  = 3'(lastb);
			return r;
		endfunction

		function void open_level();
			int unsigned base, known, nbytes, maxb, pos, c;
			bit ct;
			base = 3 * (level - 1);
			pos  = 2;
			ct   = 1'b0;
			case (level)
				1: begin
					fs[0] = SEL_CL1;
					ct    = (kbits != 0) && (klen > 4);
				end
				2: begin
					fs[0] = SEL_CL2;
					ct    = (kbits != 0) && (klen > 7);
				end
				default: fs[0] = SEL_CL3;
			endcase
			known = (kbits > 8 * base) ? kbits - 8 * base : 0;
			if (ct) begin
				fs[pos] = TAG_CT;
				pos++;
			end
			nbytes = (known + 7) / 8;
			maxb   = ct ? 3 : 4;
			if (nbytes > maxb) nbytes = maxb;
			for (c = 0; c < nbytes; c++) begin
				fs[pos] = us[base + c];
				pos++;
			end
			if (ct) known += 8;
			lkb = (known > LEVEL_BITS) ? LEVEL_BITS : known;
		endfunction

		function bit advance(item_t it, output result_t r);
			int unsigned at, align, room, n, idx, base, src, cb, rc, i;
			logic [7:0] b, mask, sak;
			r  = '0;
			cb = it.cbit;
			rc = it.rcount;
			if (it.op == OP_START) begin
				if (kbits > MAX_KNOWN_BITS) begin
					r = stop_with(OUT_BAD_ARG);
					return 1'b1;
				end
				for (i = 0; i < 8; i++) us[i] = klow[8 * i +: 8];
				us[8] = khigh[7:0];
				us[9] = khigh[15:8];
				level = 1;
				busy  = 1'b1;
				open_level();
				r = frame_beat();
				return 1'b1;
			end
			if (!busy) return 1'b0;

			if (it.link == LINK_OK || it.link == LINK_COLL) begin
				if (lkb >= LEVEL_BITS) begin
					at    = 6;
					align = 0;
				end else begin
					at    = 2 + lkb / 8;
					align = lkb % 8;
				end
				room = 9 - at;
				n    = (rc < room) ? rc : room;
				// first byte lands above the bits already sent in that byte
				for (i = 0; i < n; i++) begin
					b = it.reply[i];
					if (i == 0 && align != 0) begin
						mask = (8'd1 << align) - 8'd1;
						b    = (fs[at] & mask) | (b & ~mask);
					end
					fs[at + i] = b;
				end
			end

			case (it.link)
				LINK_COLL: begin
					if (cb <= lkb) begin
						r = stop_with(OUT_INTERNAL);
						return 1'b1;
					end
					idx = 1 + (cb + 7) / 8;
					if (idx <= 8) fs[idx] = fs[idx] | (8'd1 << ((cb - 1) % 8));
					lkb = (cb > LEVEL_BITS) ? LEVEL_BITS : cb;
					r   = frame_beat();
					return 1'b1;
				end
				LINK_TIMEOUT: begin
					r = stop_with(OUT_TIMEOUT);
					return 1'b1;
				end
				LINK_ERROR: begin
					r = stop_with(OUT_LINK);
					return 1'b1;
				end
				default: ;
			endcase

			if (lkb < LEVEL_BITS) begin
				lkb = LEVEL_BITS;
				r   = frame_beat();
				return 1'b1;
			end

			// answer to SELECT: commit level UID bytes, then look at SAK
			base = 3 * (level - 1);
			src  = (fs[2] == TAG_CT) ? 3 : 2;
			for (i = 0; i < 6 - src; i++) us[base + i] = fs[src + i];
			if (rc != 3 || it.rlast != 0) begin
				r = stop_with(OUT_BAD_SAK);
				return 1'b1;
			end
			sak = fs[6];
			if ((sak & SAK_CASCADE) != 0) begin
				if (level >= 3) begin
					r = stop_with(OUT_INTERNAL);
					return 1'b1;
				end
				level++;
				open_level();
				r = frame_beat();
				return 1'b1;
			end
			busy      = 1'b0;
			r.kind    = KIND_DONE;
			r.outcome = OUT_OK;
			for (i = 0; i < 10; i++) r.uid[i] = us[i];
			r.uid_len = 4'(3 * level + 1);
			r.sak     = sak;
			return 1'b1;
		endfunction

		function bit note_item(item_t it);
			result_t r;
			bit made;
			made = advance(it, r);
			if (made) awaited.push_back(r);
			return made;
		endfunction

		function void cmp(string nm, logic [79:0] e, logic [79:0] a);
			if (a !== e) begin
				faults++;
				$display("%0t: %s mismatch, expected %0h actual %0h", $time, nm, e, a);
			end
		endfunction

		function void check(result_t got);
			result_t e;
			if (awaited.size() == 0) begin
				faults++;
				$display("%0t: result beat with nothing expected, kind %0h", $time, got.kind);
				return;
			end
			e = awaited.pop_front();
			cmp("kind",            e.kind,      got.kind);
			cmp("frame_bytes",     e.frame,     got.frame);
			cmp("frame_count",     e.count,     got.count);
			cmp("frame_last_bits", e.last,      got.last);
			cmp("append_crc",      e.crc,       got.crc);
			cmp("outcome",         e.outcome,   got.outcome);
			cmp("uid_low",         e.uid[7:0],  got.uid[7:0]);
			cmp("uid_high",        e.uid[9:8],  got.uid[9:8]);
			cmp("uid_length",      e.uid_len,   got.uid_len);
			cmp("select_ack",      e.sak,       got.sak);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_write;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        opcode;
	logic [1:0]  link_status;
	logic [5:0]  collision_bit;
	logic [55:0] reply_bytes;
	logic [2:0]  reply_count;
	logic [2:0]  reply_last_bits;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  kind;
	logic [55:0] frame_bytes;
	logic [2:0]  frame_count;
	logic [2:0]  frame_last_bits;
	logic        append_crc;
	logic [2:0]  outcome;
	logic [63:0] uid_low;
	logic [15:0] uid_high;
	logic [3:0]  uid_length;
	logic [7:0]  select_ack;

	sel_scoreboard sb = new();
	int unsigned   quiet;
	bit            in_calm;

	iso14443a_select_anticollision_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.opcode          (opcode),
		.link_status     (link_status),
		.collision_bit   (collision_bit),
		.reply_bytes     (reply_bytes),
		.reply_count     (reply_count),
		.reply_last_bits (reply_last_bits),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.kind            (kind),
		.frame_bytes     (frame_bytes),
		.frame_count     (frame_count),
		.frame_last_bits (frame_last_bits),
		.append_crc      (append_crc),
		.outcome         (outcome),
		.uid_low         (uid_low),
		.uid_high        (uid_high),
		.uid_length      (uid_length),
		.select_ack      (select_ack)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int unsigned pause_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [55:0] rnd56();
		return 56'({$urandom, $urandom});
	endfunction

	function automatic logic [55:0] with_sak(logic [7:0] s);
		logic [55:0] v;
		v      = rnd56();
		v[7:0] = s;
		return v;
	endfunction

	function automatic item_t mk(op_t op, link_t ln, int unsigned cb, logic [55:0] rp,
		int unsigned rc, int unsigned rl);
		item_t it;
		it.op     = op;
		it.link   = ln;
		it.cbit   = 6'(cb);
		it.reply  = rp;
		it.rcount = 3'(rc);
		it.rlast  = 3'(rl);
		return it;
	endfunction

	// mostly a well-formed card answer to whatever frame is outstanding
	function automatic item_t next_item();
		item_t it;
		int unsigned r;
		it = mk(OP_RESULT, link_t'($urandom_range(0, 3)), $urandom_range(0, 63), rnd56(),
			$urandom_range(0, 7), $urandom_range(0, 7));
		r = $urandom_range(0, 99);
		if (r < 15) begin
			if (r < 4) it.op = OP_START;
			return it;
		end
		if (!sb.busy) begin
			it.op = OP_START;
			return it;
		end
		it.link  = LINK_OK;
		it.rlast = 3'd0;
		if (sb.lkb < LEVEL_BITS) begin
			it.rcount = 3'(5 - sb.lkb / 8);
			if (sb.lkb == 0 && sb.level < 3 && r < 40) it.reply[0] = TAG_CT;
			if (r < 60) begin
				it.link = LINK_COLL;
				if (r < 54) it.cbit = 6'($urandom_range(sb.lkb + 1, LEVEL_BITS));
				else it.cbit = 6'($urandom_range(LEVEL_BITS + 1, 63));
			end
		end else begin
			it.rcount       = 3'd3;
			it.reply[0][2]  = ($urandom_range(0, 1) == 1);
		end
		return it;
	endfunction

	// called and returns at a falling edge; valid is left high on return
	task automatic send(input item_t it, output bit made);
		int unsigned gap;
		if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
		gap = in_calm ? 0 : pause_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid        <= 1'b1;
		opcode          <= it.op;
		link_status     <= it.link;
		collision_bit   <= it.cbit;
		reply_bytes     <= it.reply;
		reply_count     <= it.rcount;
		reply_last_bits <= it.rlast;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		made = sb.note_item(it);
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.awaited.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic put_reg(logic [1:0] idx, logic [63:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
		@(negedge clk);
	endtask

	task automatic write_regs(logic [63:0] kb, logic [63:0] len, logic [63:0] lo,
		logic [63:0] hi);
		put_reg(CFG_KNOWN_BIT_COUNT, kb);
		put_reg(CFG_KNOWN_UID_LENGTH, len);
		put_reg(CFG_KNOWN_UID_LOW, lo);
		put_reg(CFG_KNOWN_UID_HIGH, hi);
		cfg_write <= 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet <= 0;
		end else begin
			if (out_valid && !out_stall)
				sb.check(result_t'({kind, frame_bytes, frame_count, frame_last_bits,
					append_crc, outcome, uid_high, uid_low, uid_length, select_ack}));
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
			else quiet <= quiet + 1;
		end
	end

	initial begin
		int unsigned n;
		bit calm;
		out_stall = 1'b0;
		forever begin
			calm = ($urandom_range(0, 15) == 0);
			repeat ($urandom_range(1, calm ? 150 : 6)) @(negedge clk);
			n = calm ? 0 : pause_len();
			if (n != 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		wait (quiet >= QUIET_LIMIT);
		$display("** iso14443a_select_anticollision_core: FAILED **");
		$finish;
	end

	initial begin
		bit made;
		int unsigned p, k, target, count;
		logic [63:0] kb, len, lo, hi;
		arst_n          = 1'b0;
		cfg_write       = 1'b0;
		cfg_index       = CFG_KNOWN_BIT_COUNT;
		cfg_data        = '0;
		in_valid        = 1'b0;
		opcode          = OP_START;
		link_status     = LINK_OK;
		collision_bit   = '0;
		reply_bytes     = '0;
		reply_count     = '0;
		reply_last_bits = '0;
		in_calm         = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_regs(64'd0, 64'd0, {$urandom, $urandom}, {$urandom, $urandom});
		// first dialog writes every frame store byte before anything reads one
		send(mk(OP_START, LINK_OK, 0, '0, 0, 0), made);
		send(mk(OP_RESULT, LINK_OK, 0, '1, 7, 0), made);
		send(mk(OP_RESULT, LINK_OK, 0, with_sak(SAK_CASCADE), 3, 0), made);
		send(mk(OP_RESULT, LINK_COLL, 0, '0, 0, 0), made);
		send(mk(OP_RESULT, LINK_OK, 63, '1, 7, 7), made);
		send(mk(OP_START, LINK_OK, 0, '0, 0, 0), made);
		send(mk(OP_RESULT, LINK_COLL, 12, rnd56(), 5, 4), made);
		send(mk(OP_RESULT, LINK_OK, 0, rnd56(), 4, 0), made);
		send(mk(OP_RESULT, LINK_OK, 0, with_sak(8'h00), 3, 0), made);
		send(mk(OP_START, LINK_COLL, 63, '1, 7, 7), made);
		send(mk(OP_RESULT, LINK_COLL, 63, '0, 0, 0), made);
		send(mk(OP_RESULT, LINK_OK, 0, '1, 7, 7), made);
		send(mk(OP_START, LINK_OK, 0, rnd56(), 0, 0), made);
		send(mk(OP_START, LINK_ERROR, 5, rnd56(), 2, 1), made);
		send(mk(OP_RESULT, LINK_TIMEOUT, 0, rnd56(), 7, 0), made);
		send(mk(OP_START, LINK_OK, 0, '0, 0, 0), made);
		send(mk(OP_RESULT, LINK_ERROR, 0, rnd56(), 3, 0), made);
		send(mk(OP_START, LINK_OK, 0, '0, 0, 0), made);
		// cascade bit on every level runs past level three
		for (k = 0; k < 3; k++) begin
			send(mk(OP_RESULT, LINK_OK, 0, '0, 0, 0), made);
			send(mk(OP_RESULT, LINK_OK, 0, with_sak(8'hFC), 3, 0), made);
		end
		settle();
		write_regs(64'(MAX_KNOWN_BITS) + 64'd1, 64'd10, {$urandom, $urandom}, '0);
		send(mk(OP_START, LINK_OK, 0, '0, 0, 0), made);
		settle();
		write_regs(64'(MAX_KNOWN_BITS), 64'd10, '1, '1);
		send(mk(OP_START, LINK_OK, 0, '0, 0, 0), made);
		send(mk(OP_RESULT, LINK_OK, 0, with_sak(SAK_CASCADE), 3, 0), made);
		send(mk(OP_RESULT, LINK_OK, 0, with_sak(SAK_CASCADE), 3, 0), made);
		send(mk(OP_RESULT, LINK_OK, 0, with_sak(8'h20), 3, 0), made);

		for (p = 0; p < 7; p++) begin
			settle();
			kb  = {$urandom, $urandom};
			len = {$urandom, $urandom};
			lo  = {$urandom, $urandom};
			hi  = {$urandom, $urandom};
			case (p)
				0: begin
					kb[7:0]  = 8'd0;
					len[3:0] = 4'd0;
					lo       = '0;
					hi       = '0;
				end
				1: begin
					kb[7:0]  = MAX_KNOWN_BITS;
					len[3:0] = 4'd10;
					lo       = '1;
					hi       = '1;
				end
				2: begin
					kb       = '1;
					len      = '1;
				end
				default: begin
					if ($urandom_range(0, 99) < 85) kb[7:0] = 8'($urandom_range(0, 80));
					else kb[7:0] = 8'($urandom_range(81, 255));
				end
			endcase
			write_regs(kb, len, lo, hi);
			target = (p == 2) ? 30 : 110;
			count  = 0;
			while (count < target) begin
				send(next_item(), made);
				count += made;
			end
		end
		settle();

		if (sb.faults == 0) begin
			$display("** iso14443a_select_anticollision_core: PASSED **");
		end else begin
			$display("** iso14443a_select_anticollision_core: FAILED **");
		end
		$finish;
	end

endmodule
